>>> src/swm_pkg.sv
// Shared constants and types for the sliding window maximum block.
`default_nettype none

package swm_pkg;

    // Sample and window sizing
    localparam int SAMPLE_WIDTH = 16;
    localparam int WINDOW_MAX   = 64;
    localparam int FILL_WIDTH   = $clog2(WINDOW_MAX + 1);
    localparam int CFG_WIDTH    = 7;

    // Max tree shape: leaves padded to a power of two, at least one level
    localparam int TREE_LEVELS  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int LEAVES       = 1 << TREE_LEVELS;

    // Register port
    localparam int APB_ADDR_WIDTH  = 3;
    localparam int APB_DATA_WIDTH  = 32;
    localparam int REG_INDEX_WIDTH = APB_ADDR_WIDTH - 2;

    typedef enum logic [REG_INDEX_WIDTH-1:0] {
        REG_WINDOW_SIZE = 1'b0
    } reg_index_t;

    // One stored candidate: a sample and whether it still competes
    typedef struct packed {
        logic                           valid;
        logic signed [SAMPLE_WIDTH-1:0] value;
    } cand_t;

endpackage

`default_nettype wire

>>> src/sliding_window_maximum_core.sv
// Top level of the sliding window maximum block.
//
// Streaming maximum over the last window_size signed samples (1 to 64; 0 acts
// as 1, larger values as 64). Samples shift down a chain of 64 cells, one place
// per request, and each cell keeps a flag that drops when the sample ages out
// of the window, when a newer sample is strictly larger, or when stream_start
// restarts the stream. A registered max tree of six levels over the flagged
// cells gives the result, which window_max shows from the last tree stage.
// One request per cycle is taken as long as the output side keeps up; a
// stall on the output backs up through the tree stages and then raises
// in_stall. No result comes out until window_size samples of the current
// stream have arrived.
`default_nettype none

module sliding_window_maximum_core
    import swm_pkg::*;
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic signed [SAMPLE_WIDTH-1:0] sample,
    input  wire logic                           stream_start,

    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic signed [SAMPLE_WIDTH-1:0]      window_max,

    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [APB_ADDR_WIDTH-1:0]      paddr,
    input  wire logic [APB_DATA_WIDTH-1:0]      pwdata,
    output logic [APB_DATA_WIDTH-1:0]           prdata,
    output logic                                pready
);

    logic [CFG_WIDTH-1:0]   window_size_reg;
    logic [FILL_WIDTH-1:0]  fill_count_reg;
    logic [FILL_WIDTH-1:0]  fill_count_next;
    logic [FILL_WIDTH-1:0]  fill_base;
    logic [FILL_WIDTH-1:0]  win_eff;
    logic                   head_valid_reg;
    logic                   head_ready;
    logic                   ready0;
    logic                   accept;
    logic                   emit;
    logic                   cfg_write;
    reg_index_t             reg_index;
    cand_t                  cells [WINDOW_MAX];
    cand_t                  entry;

    // Register port
    assign pready    = 1'b1;
    assign reg_index = reg_index_t'(paddr[APB_ADDR_WIDTH-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (reg_index)
            REG_WINDOW_SIZE: prdata = APB_DATA_WIDTH'(window_size_reg);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= CFG_WIDTH'(1);
        end
        else if (cfg_write && (reg_index == REG_WINDOW_SIZE))
        begin
            window_size_reg <= pwdata[CFG_WIDTH-1:0];
        end
    end

    // Clamp the window to the chain length
    always_comb
    begin
        if (window_size_reg == '0)
        begin
            win_eff = FILL_WIDTH'(1);
        end
        else if (int'(window_size_reg) > WINDOW_MAX)
        begin
            win_eff = FILL_WIDTH'(WINDOW_MAX);
        end
        else
        begin
            win_eff = FILL_WIDTH'(window_size_reg);
        end
    end

    // Take a request while the head slot is free or moving into the tree
    assign ready0   = !head_valid_reg || head_ready;
    assign in_stall = !ready0;
    assign accept   = in_valid && ready0;

    // Count samples of the current stream, saturating at the chain length
    always_comb
    begin
        fill_base = stream_start ? '0 : fill_count_reg;
        if (int'(fill_base) < WINDOW_MAX)
        begin
            fill_count_next = fill_base + FILL_WIDTH'(1);
        end
        else
        begin
            fill_count_next = fill_base;
        end
        emit = (fill_count_next >= win_eff);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg <= '0;
            head_valid_reg <= 1'b0;
        end
        else if (ready0)
        begin
            if (accept)
            begin
                fill_count_reg <= fill_count_next;
            end
            head_valid_reg <= accept && emit;
        end
    end

    // New sample enters the first cell as a live candidate
    assign entry.valid = 1'b1;
    assign entry.value = sample;

    swm_cell u_cell_first (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .clear      (1'b0),
        .in_window  (1'b1),
        .prev       (entry),
        .new_sample (sample),
        .cand       (cells[0])
    );

    // Cell i holds the sample of age i
    for (genvar i = 1; i < WINDOW_MAX; i++)
    begin : g_cell
        swm_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .load       (accept),
            .clear      (stream_start),
            .in_window  (win_eff > FILL_WIDTH'(i)),
            .prev       (cells[i - 1]),
            .new_sample (sample),
            .cand       (cells[i])
        );
    end

    swm_max_tree u_tree (
        .clk        (clk),
        .rst_n      (rst_n),
        .leaves     (cells),
        .head_valid (head_valid_reg),
        .head_ready (head_ready),
        .max_valid  (out_valid),
        .max_stall  (out_stall),
        .max_value  (window_max)
    );

`ifndef ASSERT_OFF
    logic [WINDOW_MAX-1:0] order_ok;

    // Older kept candidates never fall below newer kept ones
    for (genvar i = 0; i < WINDOW_MAX; i++)
    begin : g_order
        if (i < WINDOW_MAX - 1)
        begin : g_pair
            assign order_ok[i] = !(cells[i].valid && cells[i + 1].valid)
                || ($signed(cells[i + 1].value) >= $signed(cells[i].value));
        end
        else
        begin : g_last
            assign order_ok[i] = 1'b1;
        end
    end

    a_newest_kept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> cells[0].valid && (cells[0].value == $past(sample)))
        else $error("newest sample not kept as candidate");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        &order_ok)
        else $error("candidate order broken");

    a_restart_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        accept && stream_start && (win_eff > FILL_WIDTH'(1)) |=> !head_valid_reg)
        else $error("result issued on first sample of a wide window");
`endif

endmodule

`default_nettype wire

>>> src/swm_cell.sv
// One cell of the sample shift chain with its candidate flag.
`default_nettype none

module swm_cell
    import swm_pkg::*;
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           load,
    input  wire logic                           clear,
    input  wire logic                           in_window,
    input  wire cand_t                          prev,
    input  wire logic signed [SAMPLE_WIDTH-1:0] new_sample,
    output cand_t                               cand
);

    logic                           valid_reg;
    logic                           valid_next;
    logic signed [SAMPLE_WIDTH-1:0] value_reg;
    logic                           beaten;

    // Drop the neighbor's entry if it ages out, is beaten or the stream restarts
    always_comb
    begin
        beaten     = ($signed(prev.value) < $signed(new_sample));
        valid_next = prev.valid && in_window && !clear && !beaten;
    end

    // Hold the candidate flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= valid_next;
        end
    end

    // Advance the sample value one place down the chain
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            value_reg <= prev.value;
        end
    end

    assign cand.valid = valid_reg;
    assign cand.value = value_reg;

endmodule

`default_nettype wire

>>> src/swm_max_node.sv
// Registered two-input node of the max tree.
`default_nettype none

module swm_max_node
    import swm_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  en,
    input  wire cand_t a,
    input  wire cand_t b,
    output cand_t      m
);

    cand_t m_reg;
    cand_t m_next;

    // Pick the larger valid entry; invalid entries lose
    always_comb
    begin
        if (!a.valid)
        begin
            m_next = b;
        end
        else if (!b.valid)
        begin
            m_next = a;
        end
        else if ($signed(a.value) >= $signed(b.value))
        begin
            m_next = a;
        end
        else
        begin
            m_next = b;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg <= m_next;
        end
    end

    assign m = m_reg;

endmodule

`default_nettype wire

>>> src/swm_max_tree.sv
// Pipelined max tree over the cell chain with its request tracking.
`default_nettype none

module swm_max_tree
    import swm_pkg::*;
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire cand_t                          leaves [WINDOW_MAX],
    input  wire logic                           head_valid,
    output logic                                head_ready,
    output logic                                max_valid,
    input  wire logic                           max_stall,
    output logic signed [SAMPLE_WIDTH-1:0]      max_value
);

    cand_t heap [1:2*LEAVES-1];
    logic  stage_valid_reg [1:TREE_LEVELS];
    logic  stage_ready     [1:TREE_LEVELS];

    // Fill the leaf row, padding past the chain with empty entries
    for (genvar i = 0; i < LEAVES; i++)
    begin : g_leaf
        if (i < WINDOW_MAX)
        begin : g_used
            assign heap[LEAVES + i] = leaves[i];
        end
        else
        begin : g_pad
            assign heap[LEAVES + i] = '0;
        end
    end

    // Internal nodes: depth d loads with stage TREE_LEVELS - d
    for (genvar n = 1; n < LEAVES; n++)
    begin : g_node
        localparam int DEPTH = $clog2(n + 1) - 1;

        swm_max_node u_node (
            .clk (clk),
            .en  (stage_ready[TREE_LEVELS - DEPTH]),
            .a   (heap[2*n]),
            .b   (heap[2*n + 1]),
            .m   (heap[n])
        );
    end

    // A stage may load when empty or when its request moves on
    always_comb
    begin
        stage_ready[TREE_LEVELS] = !stage_valid_reg[TREE_LEVELS] || !max_stall;
        for (int s = TREE_LEVELS - 1; s >= 1; s--)
        begin
            stage_ready[s] = !stage_valid_reg[s] || stage_ready[s + 1];
        end
    end

    // Advance request flags through the stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 1; s <= TREE_LEVELS; s++)
            begin
                stage_valid_reg[s] <= 1'b0;
            end
        end
        else
        begin
            if (stage_ready[1])
            begin
                stage_valid_reg[1] <= head_valid;
            end
            for (int s = 2; s <= TREE_LEVELS; s++)
            begin
                if (stage_ready[s])
                begin
                    stage_valid_reg[s] <= stage_valid_reg[s - 1];
                end
            end
        end
    end

    assign head_ready = stage_ready[1];
    assign max_valid  = stage_valid_reg[TREE_LEVELS];
    assign max_value  = heap[1].value;

endmodule

`default_nettype wire

>>> sim/testbench.sv
// Self-checking testbench for the sliding window maximum core.
`default_nettype none

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import swm_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_CYCLES  = 24;
    localparam int HOLD_CYCLES   = 300;
    localparam int SEGMENTS      = 19;
    localparam int SEGMENT_ITEMS = 100;
    localparam int PRESSURE_SEG  = 14;
    localparam int REPORT_LIMIT  = 10;

    localparam logic [APB_ADDR_WIDTH-1:0] WINDOW_ADDR = {REG_WINDOW_SIZE, 2'b00};

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

    // What a directed row does and what it expects
    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_FREE,
        ROW_NONE,
        ROW_VALUE
    } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [31:0] data;
        logic        start;
        sample_t     want;
    } step_row_t;

    // Shape of the samples within one random stream
    typedef enum int {
        SHAPE_NOISE,
        SHAPE_NARROW,
        SHAPE_RISE,
        SHAPE_FALL,
        SHAPE_RAIL
    } shape_t;

    typedef struct {
        sample_t     value;
        int unsigned age;
    } cand_entry_t;

    // Reset state, extremes, window zero and above range, mid-stream changes
    localparam step_row_t DIRECTED [27] = '{
        '{ROW_VALUE, 32'h0000_0000, 1'b0, 16'h0000},
        '{ROW_VALUE, 32'h0000_7fff, 1'b0, 16'h7fff},
        '{ROW_VALUE, 32'h0000_8000, 1'b0, 16'h8000},
        '{ROW_VALUE, 32'h0000_ffff, 1'b1, 16'hffff},
        '{ROW_WRITE, 32'd0,         1'b0, 16'h0000},
        '{ROW_VALUE, 32'h0000_0005, 1'b0, 16'h0005},
        '{ROW_WRITE, 32'd3,         1'b0, 16'h0000},
        '{ROW_NONE,  32'h0000_0064, 1'b1, 16'h0000},
        '{ROW_NONE,  32'h0000_ff38, 1'b0, 16'h0000},
        '{ROW_VALUE, 32'h0000_0032, 1'b0, 16'h0064},
        '{ROW_VALUE, 32'h0000_0032, 1'b0, 16'h0032},
        '{ROW_VALUE, 32'h0000_8000, 1'b0, 16'h0032},
        '{ROW_VALUE, 32'h0000_8000, 1'b0, 16'h0032},
        '{ROW_VALUE, 32'h0000_8000, 1'b0, 16'h8000},
        '{ROW_WRITE, 32'ha5a5_a585, 1'b0, 16'h0000},
        '{ROW_FREE,  32'h0000_0007, 1'b0, 16'h0000},
        '{ROW_FREE,  32'h0000_fff9, 1'b0, 16'h0000},
        '{ROW_WRITE, 32'd127,       1'b0, 16'h0000},
        '{ROW_FREE,  32'h0000_0001, 1'b0, 16'h0000},
        '{ROW_WRITE, 32'd65,        1'b0, 16'h0000},
        '{ROW_FREE,  32'h0000_0002, 1'b0, 16'h0000},
        '{ROW_WRITE, 32'd2,         1'b0, 16'h0000},
        '{ROW_FREE,  32'h0000_fffd, 1'b0, 16'h0000},
        '{ROW_FREE,  32'h0000_fffc, 1'b0, 16'h0000},
        '{ROW_FREE,  32'h0000_7fff, 1'b0, 16'h0000},
        '{ROW_WRITE, 32'd64,        1'b0, 16'h0000},
        '{ROW_FREE,  32'h0000_8000, 1'b1, 16'h0000}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic    in_valid = 1'b0;
    logic    in_stall;
    sample_t sample = '0;
    logic    stream_start = 1'b0;

    logic    out_valid;
    logic    out_stall = 1'b0;
    sample_t window_max;

    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [APB_ADDR_WIDTH-1:0] paddr = '0;
    logic [APB_DATA_WIDTH-1:0] pwdata = '0;
    logic [APB_DATA_WIDTH-1:0] prdata;
    logic                      pready;

    // Window predictor state
    cand_entry_t          cand_q[$];
    int unsigned          fill_n = 0;
    logic [CFG_WIDTH-1:0] window_reg = 7'd1;

    // Expected window maxima, oldest first
    sample_t max_q[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    logic        holding = 1'b0;
    logic        pressure_go = 1'b0;

    int unsigned cycle_n = 0;
    int unsigned error_n = 0;
    int unsigned items_n = 0;
    int unsigned maxima_n = 0;
    int unsigned writes_n = 0;
    int unsigned backpressure_n = 0;

    sliding_window_maximum_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample       (sample),
        .stream_start (stream_start),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .window_max   (window_max),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Clamp the programmed window to the supported range
    function automatic int unsigned active_window();
        if (window_reg == 0)
            return 1;
        if (window_reg > WINDOW_MAX)
            return WINDOW_MAX;
        return 32'(window_reg);
    endfunction

    // Advance the candidate list by one sample; return 1 when a maximum is due
    function automatic bit advance_window(input sample_t s, input logic st,
                                          output sample_t mx);
        cand_entry_t kept[$];
        cand_entry_t fresh;
        int unsigned k;
        k = active_window();
        if (st)
        begin
            cand_q.delete();
            fill_n = 0;
        end
        // age candidates and drop those that left the window
        foreach (cand_q[i])
        begin
            if (cand_q[i].age + 1 < k)
            begin
                fresh.value = cand_q[i].value;
                fresh.age   = cand_q[i].age + 1;
                kept        = {kept, fresh};
            end
        end
        // drop strictly smaller candidates, ties keep the older one
        while (kept.size() > 0 && kept[$].value < s)
            kept.delete(kept.size() - 1);
        fresh.value = s;
        fresh.age   = 0;
        kept        = {kept, fresh};
        cand_q = kept;
        if (fill_n < WINDOW_MAX)
            fill_n++;
        mx = cand_q[0].value;
        return fill_n >= k;
    endfunction

    // Offer one request, wait for it to be taken, then log what it should produce
    task automatic take_sample(input sample_t s, input logic st, input row_kind_t kind,
                               input sample_t want);
        sample_t mx;
        bit      emits;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        sample       <= s;
        stream_start <= st;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_n++;
        emits = advance_window(s, st, mx);
        if (kind == ROW_VALUE)
            max_q = {max_q, want};
        else if (kind == ROW_FREE && emits)
            max_q = {max_q, mx};
    endtask

    // Write the window size once the core has gone quiet
    task automatic write_window(input logic [31:0] data);
        in_valid <= 1'b0;
        while (max_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= WINDOW_ADDR;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        window_reg = data[CFG_WIDTH-1:0];
        writes_n++;
    endtask

    // Send shaped streams, mostly opened by a start mark
    task automatic run_segment(input int unsigned count);
        shape_t      shape;
        int unsigned left;
        sample_t     s;
        sample_t     prev;
        logic        st;
        shape = SHAPE_NOISE;
        left  = 0;
        prev  = '0;
        for (int unsigned n = 0; n < count; n++)
        begin
            st = 1'b0;
            if (left == 0)
            begin
                left  = $urandom_range(150, 1);
                shape = shape_t'($urandom_range(SHAPE_RAIL));
                st    = ($urandom_range(9) != 0);
            end
            left--;
            // stray restart in the middle of a stream
            if ($urandom_range(63) == 0)
                st = 1'b1;
            case (shape)
                SHAPE_NARROW: s = sample_t'($urandom_range(8) - 4);
                SHAPE_RISE:   s = prev + sample_t'($urandom_range(300));
                SHAPE_FALL:   s = prev - sample_t'($urandom_range(300));
                SHAPE_RAIL:   s = $urandom_range(1)
                                  ? 16'h7fff - sample_t'($urandom_range(1))
                                  : 16'h8000 + sample_t'($urandom_range(1));
                default:      s = sample_t'($urandom);
            endcase
            prev = s;
            take_sample(s, st, ROW_FREE, '0);
        end
    endtask

    // Count mismatches, report the first few
    task automatic note_mismatch(input string what, input sample_t want, input sample_t got);
        error_n++;
        if (error_n <= REPORT_LIMIT)
            $display("Mismatch on %s at cycle %0d: expected %0d, got %0d",
                     what, cycle_n, want, got);
    endtask

    // Receiver: random stall, or a long hold-off when asked
    always @(posedge clk)
        out_stall <= holding || ($urandom_range(99) < recv_idle_pct);

    // Hold off the output for a fixed stretch while requests keep coming
    initial
    begin
        wait (pressure_go);
        @(posedge clk);
        holding <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding <= 1'b0;
    end

    // Check every accepted maximum against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_stall)
                backpressure_n++;
            if (out_valid && !out_stall)
            begin
                maxima_n++;
                if (max_q.size() == 0)
                    note_mismatch("unexpected window_max", 'x, window_max);
                else if (window_max !== max_q[0])
                    note_mismatch("window_max", max_q[0], window_max);
                if (max_q.size() != 0)
                    max_q.delete(0);
            end
        end
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_n <= cycle_n + 1;
        if (cycle_n == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d maxima outstanding",
                     cycle_n, max_q.size());
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] setting;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows under sender and receiver idling
        send_idle_pct = 19;
        recv_idle_pct <= 57;
        foreach (DIRECTED[r])
        begin
            if (DIRECTED[r].kind == ROW_WRITE)
                write_window(DIRECTED[r].data);
            else
                take_sample(DIRECTED[r].data[SAMPLE_WIDTH-1:0], DIRECTED[r].start,
                            DIRECTED[r].kind, DIRECTED[r].want);
        end

        // random segments, a new window setting before each
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            if (seg < 6)
            begin
                send_idle_pct = 19;
                recv_idle_pct <= 57;
            end
            else if (seg < 12)
            begin
                send_idle_pct = 57;
                recv_idle_pct <= 19;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct <= 0;
            end
            case ($urandom_range(7))
                0:       setting = 0;
                1:       setting = 1;
                2:       setting = 2;
                3:       setting = WINDOW_MAX - 1;
                4:       setting = WINDOW_MAX;
                5:       setting = $urandom_range(127, WINDOW_MAX + 1);
                default: setting = $urandom_range(WINDOW_MAX, 1);
            endcase
            if ($urandom_range(1))
                setting = setting | ($urandom & ~32'h7f);
            // keep every sample producing a maximum while the output is held off
            if (seg == PRESSURE_SEG)
                setting = 1;
            write_window(setting);
            if (seg == PRESSURE_SEG)
                pressure_go <= 1'b1;
            run_segment(SEGMENT_ITEMS);
        end

        // drain
        in_valid <= 1'b0;
        while (max_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d samples over %0d window writes; %0d maxima checked.",
                 items_n, writes_n, maxima_n);
        $display("Input held off for %0d cycles; %0d mismatches.", backpressure_n, error_n);
        if (error_n == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

>>> sliding_window_maximum_core.f
src/swm_pkg.sv
src/swm_cell.sv
src/swm_max_node.sv
src/swm_max_tree.sv
src/sliding_window_maximum_core.sv
sim/testbench.sv
